// ----- design/bms_pkg.sv -----
// Shared types and constants for the bounded multiset table.
package bms_pkg;

	localparam int unsigned ValueW = 32;
	localparam int unsigned ModeW = 2;
	localparam int unsigned PosW = 7;
	localparam int unsigned CountW = 8;
	localparam logic [CountW-1:0] CapacityReset = 8'd100;

	typedef enum logic [ModeW-1:0] {
		MODE_ADD    = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_SWAP
	} state_t;

	typedef struct packed {
		logic [ModeW-1:0]         mode;
		logic signed [ValueW-1:0] value;
	} request_t;

	typedef struct packed {
		logic              success;
		logic [PosW-1:0]   position;
		logic [CountW-1:0] count;
	} result_t;

endpackage

// ----- design/bounded_multiset_table.sv -----
// Top level of the bounded multiset table: capacity register, sequencer and entry store.
// An operation is taken when start is high while busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off. Add and
// clear never leave the idle state, so done follows start in the next cycle and a
// new operation may be started at once. Find and remove scan the stored entries one
// per cycle through the single read port of the entry store and stay busy until a
// match or the end of the entries; a remove that matches then reads the last entry
// and writes it into the freed slot. There is no clearing pass after reset.
module bounded_multiset_table #(
	parameter int unsigned DEPTH = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  bms_pkg::request_t          request,
	output logic                       busy,
	output logic                       done,
	output bms_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bms_pkg::CountW-1:0] cfg_data
);
	import bms_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic [CountW-1:0] capacity_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [ValueW-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [ValueW-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CapacityReset;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	bms_ctrl #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.capacity(capacity_q),
		.busy(busy),
		.done(done),
		.result(result),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	bms_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// A multi-cycle operation always ends with its result beat.
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	// A result beat only follows an accepted operation or a busy cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result beat without an operation");

	// The stored count never exceeds the table depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.count <= DEPTH))
		else $error("count beyond depth");

	// A failed operation reports slot zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.success) |-> (result.position == '0))
		else $error("failed operation with nonzero position");

endmodule

// ----- design/bms_mem.sv -----
// Entry store: one write port and one read port with registered read data.
module bms_mem #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW = 7
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [bms_pkg::ValueW-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [bms_pkg::ValueW-1:0] rdata
);
	import bms_pkg::*;

	logic [ValueW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/bms_ctrl.sv -----
// Sequencer: stored count, linear scan over the entry store, swap-remove.
module bms_ctrl #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  bms_pkg::request_t           request,
	input  logic [bms_pkg::CountW-1:0]  capacity,
	output logic                        busy,
	output logic                        done,
	output bms_pkg::result_t            result,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [bms_pkg::ValueW-1:0] mem_wdata,
	output logic [AW-1:0]               mem_raddr,
	input  logic [bms_pkg::ValueW-1:0] mem_rdata
);
	import bms_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > CountW) ? CW : CountW;

	state_t          state_q, state_d;
	request_t        req_q, req_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [AW-1:0]   match_q, match_d;
	logic            rdv_s1, rdv_d;
	logic [AW-1:0]   rd_idx_s1;
	logic            done_q, done_d;
	result_t         result_q, result_d;

	logic            issue;
	logic            hit;
	logic            can_add;
	logic            res_ok;
	logic [AW-1:0]   res_slot;
	logic [CW-1:0]   cnt_m1;
	logic [AW+PosW-1:0]   pos_ext;
	logic [CW+CountW-1:0] cnt_ext;

	assign hit = rdv_s1 && (mem_rdata == req_q.value);
	assign can_add = (XW'(cnt_q) < XW'(capacity)) && (cnt_q < CW'(DEPTH));
	assign cnt_m1 = cnt_q - CW'(1);
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

	always_comb begin
		state_d = state_q;
		req_d = req_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		match_d = match_q;
		rdv_d = 1'b0;
		done_d = 1'b0;
		res_ok = 1'b0;
		res_slot = '0;
		issue = 1'b0;
		mem_we = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = request.value;
		mem_raddr = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_d = request;
					case (mode_t'(request.mode))
						MODE_ADD: begin
							done_d = 1'b1;
							if (can_add) begin
								mem_we = 1'b1;
								res_ok = 1'b1;
								res_slot = cnt_q[AW-1:0];
								cnt_d = cnt_q + CW'(1);
							end
						end
						MODE_CLEAR: begin
							done_d = 1'b1;
							res_ok = 1'b1;
							cnt_d = '0;
						end
						default: begin
							idx_d = '0;
							state_d = ST_SCAN;
						end
					endcase
				end
			end
			ST_SCAN: begin
				issue = (idx_q < cnt_q);
				if (hit) begin
					if (mode_t'(req_q.mode) == MODE_REMOVE) begin
						match_d = rd_idx_s1;
						state_d = ST_LAST;
					end else begin
						done_d = 1'b1;
						res_ok = 1'b1;
						res_slot = rd_idx_s1;
						state_d = ST_IDLE;
					end
				end else if (!issue) begin
					// Every stored entry has been compared without a match.
					done_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rdv_d = 1'b1;
					idx_d = idx_q + CW'(1);
				end
			end
			ST_LAST: begin
				mem_raddr = cnt_m1[AW-1:0];
				state_d = ST_SWAP;
			end
			ST_SWAP: begin
				// The last entry, read in the previous cycle, fills the hole.
				mem_we = 1'b1;
				mem_waddr = match_q;
				mem_wdata = mem_rdata;
				cnt_d = cnt_m1;
				done_d = 1'b1;
				res_ok = 1'b1;
				res_slot = match_q;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		pos_ext = {{PosW{1'b0}}, res_slot};
		cnt_ext = {{CountW{1'b0}}, cnt_d};
		result_d.success = res_ok;
		result_d.position = pos_ext[PosW-1:0];
		result_d.count = cnt_ext[CountW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rdv_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			rdv_s1 <= rdv_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		idx_q <= idx_d;
		match_q <= match_d;
		rd_idx_s1 <= idx_q[AW-1:0];
		result_q <= result_d;
	end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the bounded multiset table: scripted operations, then random traffic.
`timescale 1ns / 100ps

module tb_top;
	import bms_pkg::*;

	localparam int unsigned Depth = 128;
	localparam int unsigned RecentMax = 64;

	typedef struct packed {
		mode_t       op;
		logic [31:0] data;
		logic        pinned;
		result_t     want;
	} script_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	request_t          request = '0;
	logic              busy;
	logic              done;
	result_t           result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CountW-1:0] cfg_data = '0;

	// A result typed into the script travels with its request beat and replaces the prediction.
	logic    pin_valid = 1'b0;
	result_t pin_result = '0;

	// Shadow copy of the table contents and the capacity register.
	logic [ValueW-1:0] slots [Depth];
	int unsigned       fill = 0;
	logic [CountW-1:0] capacity = CapacityReset;
	result_t           outstanding [$];

	int unsigned       fails = 0;
	int unsigned       op_tally [4] = '{default: 0};
	int unsigned       hits = 0;
	int unsigned       peak = 0;
	int unsigned       cap_writes = 0;
	int unsigned       idle_pct = 23;
	logic [ValueW-1:0] recent [$];

	script_row_t script [22] = '{
		'{MODE_FIND,   32'h0000_0005, 1'b1, '{1'b0, 7'd0, 8'd0}},
		'{MODE_REMOVE, 32'h0000_0005, 1'b1, '{1'b0, 7'd0, 8'd0}},
		'{MODE_ADD,    32'h7FFF_FFFF, 1'b1, '{1'b1, 7'd0, 8'd1}},
		'{MODE_ADD,    32'h8000_0000, 1'b1, '{1'b1, 7'd1, 8'd2}},
		'{MODE_ADD,    32'h0000_0000, 1'b0, '0},
		'{MODE_ADD,    32'hFFFF_FFFF, 1'b0, '0},
		'{MODE_ADD,    32'h8000_0000, 1'b0, '0},
		'{MODE_FIND,   32'h8000_0000, 1'b1, '{1'b1, 7'd1, 8'd5}},
		'{MODE_FIND,   32'h1234_5678, 1'b1, '{1'b0, 7'd0, 8'd5}},
		'{MODE_FIND,   32'hFFFF_FFFF, 1'b0, '0},
		'{MODE_REMOVE, 32'h8000_0000, 1'b0, '0},
		'{MODE_FIND,   32'h8000_0000, 1'b0, '0},
		'{MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, '0},
		'{MODE_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{MODE_CLEAR,  32'hDEAD_BEEF, 1'b1, '{1'b1, 7'd0, 8'd0}},
		'{MODE_FIND,   32'h7FFF_FFFF, 1'b1, '{1'b0, 7'd0, 8'd0}},
		'{MODE_ADD,    32'h5555_5555, 1'b1, '{1'b1, 7'd0, 8'd1}},
		'{MODE_ADD,    32'hAAAA_AAAA, 1'b0, '0},
		'{MODE_REMOVE, 32'h5555_5555, 1'b0, '0},
		'{MODE_FIND,   32'hAAAA_AAAA, 1'b0, '0},
		'{MODE_CLEAR,  32'h0000_0000, 1'b1, '{1'b1, 7'd0, 8'd0}},
		'{MODE_REMOVE, 32'hAAAA_AAAA, 1'b1, '{1'b0, 7'd0, 8'd0}}
	};

	bounded_multiset_table #(
		.DEPTH(Depth)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one operation to the shadow table and returns the result it must produce.
	function automatic result_t apply_op(request_t req);
		result_t     res;
		int unsigned eff;
		int unsigned hit;
		res = '0;
		eff = (capacity < Depth) ? capacity : Depth;
		case (req.mode)
			MODE_ADD: begin
				if (fill < eff) begin
					slots[fill] = req.value;
					res.success = 1'b1;
					res.position = PosW'(fill);
					fill++;
				end
			end
			MODE_FIND, MODE_REMOVE: begin
				hit = Depth;
				for (int unsigned i = 0; i < fill; i++) begin
					if (slots[i] == req.value && hit == Depth) hit = i;
				end
				if (hit < Depth) begin
					res.success = 1'b1;
					res.position = PosW'(hit);
					if (req.mode == MODE_REMOVE) begin
						// The last entry moves into the freed slot.
						fill--;
						slots[hit] = slots[fill];
					end
				end
			end
			default: begin
				fill = 0;
				res.success = 1'b1;
			end
		endcase
		res.count = CountW'(fill);
		return res;
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (done) begin
			if (outstanding.size() == 0) begin
				$error("result beat with no operation outstanding");
				fails++;
			end else begin
				want = outstanding.pop_front();
				if (result.success !== want.success) begin
					$error("success: expected %0d, got %0d", want.success, result.success);
					fails++;
				end
				if (result.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, result.position);
					fails++;
				end
				if (result.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, result.count);
					fails++;
				end
			end
		end
		if (start && !busy) begin
			want = apply_op(request);
			op_tally[request.mode]++;
			if (want.success) hits++;
			if (fill > peak) peak = fill;
			if (pin_valid) want = pin_result;
			outstanding.push_back(want);
		end
		if (cfg_valid && cfg_ready) begin
			capacity = cfg_data;
			cap_writes++;
		end
	end

	// Start stays high across back-to-back beats; it only drops for an idle gap.
	task automatic issue(mode_t op, logic [ValueW-1:0] data, logic pinned, result_t want);
		start <= 1'b1;
		request <= '{mode: op, value: data};
		pin_valid <= pinned;
		pin_result <= want;
		do @(posedge clk); while (busy);
		if (op == MODE_ADD) begin
			recent.push_back(data);
			if (recent.size() > RecentMax) recent.delete(0);
		end
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Every operation yields a result, so an empty queue means the block is idle.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CountW-1:0] c);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [ValueW-1:0] v;
		logic [CountW-1:0] cap;
		mode_t             op;
		int unsigned       r;
		int unsigned       clear_pct;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) issue(script[i].op, script[i].data, script[i].pinned, script[i].want);

		write_capacity(8'd0);
		issue(MODE_ADD, $urandom(), 1'b1, '{1'b0, 7'd0, 8'd0});

		// A capacity above the depth is limited to the depth: fill the store completely.
		write_capacity(8'd255);
		repeat (Depth) issue(MODE_ADD, $urandom(), 1'b0, '0);
		repeat (2) issue(MODE_ADD, $urandom(), 1'b1, '{1'b0, 7'd0, 8'd128});
		issue(MODE_FIND, recent[recent.size() - 3], 1'b0, '0);
		issue(MODE_REMOVE, recent[0], 1'b0, '0);
		write_capacity(8'd3);
		issue(MODE_ADD, $urandom(), 1'b0, '0);
		issue(MODE_FIND, recent[$urandom_range(40)], 1'b0, '0);
		issue(MODE_CLEAR, $urandom(), 1'b1, '{1'b1, 7'd0, 8'd0});

		for (int regime = 0; regime < 3; regime++) begin
			idle_pct = (regime == 0) ? 23 : (regime == 1) ? 66 : 0;
			for (int phase = 0; phase < 5; phase++) begin
				case (phase)
					0: cap = CountW'($urandom_range(1, 12));
					1: cap = 8'd128;
					2: cap = CountW'($urandom_range(0, 255));
					3: cap = 8'd255;
					default: cap = CountW'($urandom_range(20, 100));
				endcase
				clear_pct = (phase == 1 || phase == 3) ? 1 : 6;
				write_capacity(cap);
				repeat (55) begin
					r = $urandom_range(99);
					if (r < 45) op = MODE_ADD;
					else if (r < 67) op = MODE_FIND;
					else if (r < 100 - clear_pct) op = MODE_REMOVE;
					else op = MODE_CLEAR;
					// Often recently added or small values, so finds and removes hit and duplicates pile up.
					r = $urandom_range(99);
					if (r < 40 && recent.size() != 0) v = recent[$urandom_range(recent.size() - 1)];
					else if (r < 55) v = $urandom_range(3);
					else v = $urandom();
					issue(op, v, 1'b0, '0);
				end
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Ran %0d add, %0d find, %0d remove and %0d clear operations; %0d succeeded.",
			op_tally[MODE_ADD], op_tally[MODE_FIND], op_tally[MODE_REMOVE],
			op_tally[MODE_CLEAR], hits);
		$display("Capacity was written %0d times and the table held up to %0d entries.",
			cap_writes, peak);
		if (fails == 0) begin
			$display("PASS bounded_multiset_table");
		end else begin
			$display("FAIL bounded_multiset_table");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("FAIL bounded_multiset_table");
		$finish;
	end

endmodule

// ----- files.f -----
design/bms_pkg.sv
design/bms_mem.sv
design/bms_ctrl.sv
design/bounded_multiset_table.sv
tb/tb_top.sv
